// ===== sv/aqlb_pkg.sv =====
// Package of the LED bar mapper: payload types, cutoff tables and colour tables.
`default_nettype none

package aqlb_pkg;

  // Bar geometry.
  localparam int unsigned NUM_LEDS       = 11;
  localparam logic [3:0]  LAST_LED       = 4'd10;
  localparam int unsigned LEGACY_OFFSET  = 2;
  localparam int unsigned LEGACY_SIZE    = 9;
  localparam logic [3:0]  LEGACY_MAX_LVL = 4'd9;

  // Register map: one register, bar_mode, at byte address 0.
  localparam int unsigned PADDR_W       = 3;
  localparam logic [0:0]  REG_BAR_MODE  = 1'b0;

  typedef enum logic [1:0] {
    MODE_CO2   = 2'd0,
    MODE_PM    = 2'd1,
    MODE_COMBO = 2'd2,
    MODE_OFF   = 2'd3
  } bar_mode_e;

  typedef enum logic [1:0] {
    STATUS_CLEAR  = 2'd0,
    STATUS_RED    = 2'd1,
    STATUS_ORANGE = 2'd2,
    STATUS_VIOLET = 2'd3
  } status_e;

  // Colour sequence of the combo columns; the legacy bar starts at green.
  typedef enum logic [2:0] {
    COL_BLUE   = 3'd0,
    COL_GREEN  = 3'd1,
    COL_YELLOW = 3'd2,
    COL_ORANGE = 3'd3,
    COL_RED    = 3'd4,
    COL_PURPLE = 3'd5
  } color_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef rgb_t [NUM_LEDS-1:0] frame_t;

  typedef struct packed {
    logic [1:0]         status_color;
    logic signed [11:0] temperature_half;
    logic [7:0]         humidity_half;
    logic [14:0]        co2_half;
    logic [10:0]        pm25_half;
    logic [9:0]         tvoc_half;
    logic [9:0]         nox_half;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } out_item_t;

  // Combo cutoffs in whole units; values arrive in half units.
  localparam logic [7:0]  TEMP_CUT [5] = '{8'd15, 8'd26, 8'd30, 8'd34, 8'd38};
  localparam logic [7:0]  HUM_CUT  [5] = '{8'd30, 8'd60, 8'd70, 8'd80, 8'd90};
  localparam logic [11:0] CO2_CUT  [9] = '{12'd526, 12'd654, 12'd813, 12'd1010, 12'd1256,
                                           12'd1561, 12'd1941, 12'd2413, 12'd3000};
  localparam logic [7:0]  PM_CUT   [9] = '{8'd6, 8'd10, 8'd16, 8'd25, 8'd40,
                                           8'd63, 8'd100, 8'd158, 8'd250};
  localparam logic [8:0]  IDX_CUT  [4] = '{9'd100, 9'd200, 9'd300, 9'd400};

  // Legacy lower bounds in whole units; the repeated 1000 skips a level.
  localparam logic [11:0] CO2_LVL  [9] = '{12'd600, 12'd800, 12'd1000, 12'd1000, 12'd1250,
                                           12'd1500, 12'd1750, 12'd2000, 12'd3000};
  localparam logic [7:0]  PM_LVL   [9] = '{8'd5, 8'd9, 8'd20, 8'd35, 8'd45,
                                           8'd55, 8'd100, 8'd125, 8'd225};

  localparam rgb_t RGB_CLEAR = '{red: 8'd0, green: 8'd0, blue: 8'd0};

  function automatic rgb_t combo_color(color_e c);
    rgb_t rgb;
    unique case (c)
      COL_BLUE:   rgb = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      COL_GREEN:  rgb = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      COL_YELLOW: rgb = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      COL_ORANGE: rgb = '{red: 8'd255, green: 8'd128, blue: 8'd0};
      COL_RED:    rgb = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      COL_PURPLE: rgb = '{red: 8'd180, green: 8'd0,   blue: 8'd255};
      default:    rgb = RGB_CLEAR;
    endcase
    return rgb;
  endfunction

  function automatic rgb_t status_rgb(status_e s);
    rgb_t rgb;
    unique case (s)
      STATUS_CLEAR:  rgb = RGB_CLEAR;
      STATUS_RED:    rgb = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      STATUS_ORANGE: rgb = '{red: 8'd233, green: 8'd183, blue: 8'd54};
      STATUS_VIOLET: rgb = '{red: 8'd139, green: 8'd24,  blue: 8'd248};
      default:       rgb = RGB_CLEAR;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// ===== sv/aqlb_frame.sv =====
// Colour frame of all eleven LEDs for one registered measurement set.
`default_nettype none

module aqlb_frame (
  input  aqlb_pkg::in_item_t  item_i,
  input  aqlb_pkg::bar_mode_e mode_i,
  output aqlb_pkg::frame_t    frame_o
);
  import aqlb_pkg::*;

  logic [3:0]  temp_lvl, hum_lvl, co2_lvl, pm_lvl, tvoc_lvl, nox_lvl, leg_lvl;
  logic        is_co2;
  logic [14:0] leg_half;
  logic [15:0] leg_sum;
  logic [14:0] leg_round;
  logic [3:0]  leg_len;
  rgb_t        leg_rgb;
  rgb_t        led0_rgb;

  // Combo levels: count of cutoffs whose double lies at or below the value.
  always_comb begin
    temp_lvl = '0;
    hum_lvl  = '0;
    for (int j = 0; j < 5; j++) begin
      temp_lvl = temp_lvl + 4'(item_i.temperature_half >=
                               $signed({3'b000, TEMP_CUT[j], 1'b0}));
      hum_lvl  = hum_lvl + 4'({1'b0, item_i.humidity_half} >= {HUM_CUT[j], 1'b0});
    end
    co2_lvl = '0;
    pm_lvl  = '0;
    for (int j = 0; j < 9; j++) begin
      co2_lvl = co2_lvl + 4'(item_i.co2_half >= {2'b00, CO2_CUT[j], 1'b0});
      pm_lvl  = pm_lvl + 4'(item_i.pm25_half >= {2'b00, PM_CUT[j], 1'b0});
    end
    tvoc_lvl = '0;
    nox_lvl  = '0;
    for (int j = 0; j < 4; j++) begin
      tvoc_lvl = tvoc_lvl + 4'(item_i.tvoc_half >= {IDX_CUT[j], 1'b0});
      nox_lvl  = nox_lvl + 4'(item_i.nox_half >= {IDX_CUT[j], 1'b0});
    end
  end

  // Legacy level: value rounded half up, counted against the lower bounds.
  always_comb begin
    is_co2    = (mode_i == MODE_CO2);
    leg_half  = is_co2 ? item_i.co2_half : {4'b0000, item_i.pm25_half};
    leg_sum   = {1'b0, leg_half} + 16'd1;
    leg_round = leg_sum[15:1];
    leg_lvl   = '0;
    for (int j = 0; j < 9; j++) begin
      if (is_co2) begin
        leg_lvl = leg_lvl + 4'({3'b000, CO2_LVL[j]} < leg_round);
      end else begin
        leg_lvl = leg_lvl + 4'({7'b0000000, PM_LVL[j]} < leg_round);
      end
    end
    // The skipped CO2 level shortens the bar by one from level three up.
    leg_len = (is_co2 && (leg_lvl >= 4'd3)) ? leg_lvl : leg_lvl + 4'd1;
    leg_rgb = combo_color(color_e'(3'd1 + leg_lvl[3:1]));
  end

  // An active status colour takes the temperature LED in combo mode.
  always_comb begin
    if (status_e'(item_i.status_color) != STATUS_CLEAR) begin
      led0_rgb = status_rgb(status_e'(item_i.status_color));
    end else begin
      led0_rgb = combo_color(color_e'(temp_lvl[2:0]));
    end
  end

  // Assemble the frame for the selected mode.
  always_comb begin
    frame_o = '0;
    unique case (mode_i)
      MODE_COMBO: begin
        frame_o[0] = led0_rgb;
        frame_o[1] = combo_color(color_e'(hum_lvl[2:0]));
        frame_o[3] = combo_color(color_e'(3'd1 + co2_lvl[3:1]));
        frame_o[4] = co2_lvl[0] ? combo_color(color_e'(3'd1 + co2_lvl[3:1])) : RGB_CLEAR;
        frame_o[6] = pm_lvl[0] ? combo_color(color_e'(3'd1 + pm_lvl[3:1])) : RGB_CLEAR;
        frame_o[7] = combo_color(color_e'(3'd1 + pm_lvl[3:1]));
        frame_o[9]  = combo_color(color_e'(3'd1 + tvoc_lvl[2:0]));
        frame_o[10] = combo_color(color_e'(3'd1 + nox_lvl[2:0]));
      end
      MODE_CO2, MODE_PM: begin
        frame_o[0] = status_rgb(status_e'(item_i.status_color));
        for (int j = 0; j < LEGACY_SIZE; j++) begin
          if (leg_lvl == LEGACY_MAX_LVL) begin
            frame_o[LEGACY_OFFSET + j] = (j % 2 == 1) ? combo_color(COL_RED)
                                                      : combo_color(COL_PURPLE);
          end else if ({1'b0, 4'(j)} + {1'b0, leg_len} >= 5'(LEGACY_SIZE)) begin
            frame_o[LEGACY_OFFSET + j] = leg_rgb;
          end
        end
      end
      MODE_OFF: frame_o = '0;
      default:  frame_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/air_quality_led_bar_mapper.sv =====
// Top level of the LED bar mapper: input register, frame register, LED serialiser, APB register.
//
//   channel  direction  handshake                    payload
//   in       in         in_valid_i / in_stall_o      in_data_i  (aqlb_pkg::in_item_t)
//   out      out        out_valid_o / out_stall_i    out_data_o (aqlb_pkg::out_item_t)
//   apb      in         psel_i, penable_i, pready_o  bar_mode at byte address 0
//
// One measurement set yields eleven LED transactions, one per cycle when unstalled; the
// LED serialiser on the output sets the sustained rate of measurement sets.
// The first LED appears after the input register and then the frame register take the set.
// The next set is taken into the input register while the current frame is still going out.
// Reset empties both stages and sets bar_mode to combo columns. An output stall holds LED.
`default_nettype none

module air_quality_led_bar_mapper (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // Measurement input
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  aqlb_pkg::in_item_t             in_data_i,
  // LED output
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output aqlb_pkg::out_item_t            out_data_o,
  // Configuration port
  input  wire                            psel_i,
  input  wire                            penable_i,
  input  wire                            pwrite_i,
  input  wire [aqlb_pkg::PADDR_W-1:0]    paddr_i,
  input  wire [31:0]                     pwdata_i,
  output logic [31:0]                    prdata_o,
  output logic                           pready_o
);
  import aqlb_pkg::*;

  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  frame_t    frame_q, frame_d;
  logic      frame_valid_q, frame_valid_d;
  logic [3:0] idx_q, idx_d;
  bar_mode_e bar_mode_q, bar_mode_d;

  logic in_accept, out_fire, out_last, frame_free, load_frame, in_free;
  logic reg_write;

  // Handshake between the two stages.
  assign out_last   = (idx_q == LAST_LED);
  assign out_fire   = frame_valid_q && !out_stall_i;
  assign frame_free = !frame_valid_q || (out_fire && out_last);
  assign load_frame = in_valid_q && frame_free;
  assign in_free    = !in_valid_q || load_frame;
  assign in_stall_o = !in_free;
  assign in_accept  = in_valid_i && in_free;

  // Frame colours from the registered measurement set.
  aqlb_frame u_frame (
    .item_i  (in_q),
    .mode_i  (bar_mode_q),
    .frame_o (frame_d)
  );

  // Input register.
  assign in_valid_d = in_accept ? 1'b1 : (load_frame ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Frame register and LED counter.
  always_comb begin
    frame_valid_d = frame_valid_q;
    idx_d         = idx_q;
    if (load_frame) begin
      frame_valid_d = 1'b1;
      idx_d         = '0;
    end else if (out_fire) begin
      idx_d = idx_q + 4'd1;
      if (out_last) begin
        frame_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
      idx_q         <= '0;
    end else begin
      frame_valid_q <= frame_valid_d;
      idx_q         <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_frame) begin
      frame_q <= frame_d;
    end
  end

  // Output transaction for the current LED.
  always_comb begin
    out_valid_o          = frame_valid_q;
    out_data_o.led_index = idx_q;
    out_data_o.red       = frame_q[idx_q].red;
    out_data_o.green     = frame_q[idx_q].green;
    out_data_o.blue      = frame_q[idx_q].blue;
    out_data_o.last_led  = out_last;
  end

  // Configuration register; the low address bits are ignored, only the top bit selects it.
  assign pready_o   = 1'b1;
  assign reg_write  = psel_i && penable_i && pwrite_i && pready_o &&
                      (paddr_i[PADDR_W-1] == REG_BAR_MODE);
  assign bar_mode_d = reg_write ? bar_mode_e'(pwdata_i[1:0]) : bar_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_mode_q <= MODE_COMBO;
    end else begin
      bar_mode_q <= bar_mode_d;
    end
  end

  assign prdata_o = (paddr_i[PADDR_W-1] == REG_BAR_MODE) ? {30'd0, bar_mode_q} : 32'd0;

endmodule

`default_nettype wire
